@@ rtl/tsop_pkg.sv @@
// Shared types and constants for the TCP SACK option parser.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tsop_pkg;

  localparam int EdgeW = 32;
  localparam int CntW  = 3;

  // Most blocks kept from one SACK option (1 to 4).
  localparam logic [CntW-1:0] MaxBlocks = 3'd4;

  localparam logic [7:0] KindEol     = 8'd0;
  localparam logic [7:0] KindNop     = 8'd1;
  localparam logic [7:0] KindSack    = 8'd5;
  localparam logic [7:0] SackMinLen  = 8'd10;
  localparam logic [2:0] PairLeftPos = 3'd4;
  localparam logic [2:0] PairEndPos  = 3'd0;

  typedef logic [3:0][EdgeW-1:0] edges_t;

  // One edge pair handed from the option walker to the block store.
  typedef struct packed {
    logic             clear;       // new SACK option starts, drop the block list
    logic             valid;       // a complete pair is offered
    logic [EdgeW-1:0] left;
    logic [EdgeW-1:0] right;
    logic [EdgeW-1:0] win_una;
    logic [EdgeW-1:0] win_nxt;
  } pair_t;

endpackage

`default_nettype wire

@@ rtl/tcp_sack_option_parser_core.sv @@
//  Channel  Signals                                 Direction  Transfer
//  in       in_valid_i / in_ready_o, option byte    in         one option byte per transfer
//  out      out_valid_o / out_ready_i, SACK result  out        one result per final byte
//  cfg      cfg_we_i, cfg_wdata_i                   in         write on enable, no wait
//
// Throughput is one option byte per cycle. A byte sits in the input register;
// the walker and the block store update from it as it steps on, and the final
// byte loads the result register, which raises out_valid_o. Reset clears the
// walk to expecting an option kind and sack_permitted to 0. Only a final byte
// waits on a full result register; other bytes always move on.
// Depends on tsop_pkg, tsop_walk and tsop_blocks.
`timescale 1ns / 1ps
`default_nettype none

module tcp_sack_option_parser_core import tsop_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       opt_byte_i,
  input  wire logic             end_of_area_i,
  input  wire logic [EdgeW-1:0] send_next_i,
  input  wire logic [EdgeW-1:0] outstanding_bytes_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  sack_updated_o,
  output logic [CntW-1:0]       block_count_o,
  output logic [EdgeW-1:0]      block_left_0_o,
  output logic [EdgeW-1:0]      block_right_0_o,
  output logic [EdgeW-1:0]      block_left_1_o,
  output logic [EdgeW-1:0]      block_right_1_o,
  output logic [EdgeW-1:0]      block_left_2_o,
  output logic [EdgeW-1:0]      block_right_2_o,
  output logic [EdgeW-1:0]      block_left_3_o,
  output logic [EdgeW-1:0]      block_right_3_o
);

  logic             permitted_q;
  logic             in_vld_q;
  logic [7:0]       byte_q;
  logic             end_q;
  logic [EdgeW-1:0] nxt_q, outst_q;
  logic             out_vld_q;
  logic             step;
  pair_t            pair;
  logic             complete;
  logic [CntW-1:0]  cnt;
  edges_t           lefts, rights;
  logic             upd_q;
  logic [CntW-1:0]  cnt_q;
  edges_t           left_q, right_q;

  // A final byte may only go ahead once the result register has room.
  assign step       = in_vld_q && (!end_q || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      permitted_q <= 1'b0;
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        permitted_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (step && end_q) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= opt_byte_i;
      end_q   <= end_of_area_i;
      nxt_q   <= send_next_i;
      outst_q <= outstanding_bytes_i;
    end
  end

  tsop_walk u_walk (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .step_i              (step),
    .permitted_i         (permitted_q),
    .opt_byte_i          (byte_q),
    .end_of_area_i       (end_q),
    .send_next_i         (nxt_q),
    .outstanding_bytes_i (outst_q),
    .pair_o              (pair),
    .complete_o          (complete)
  );

  tsop_blocks u_blocks (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .pair_i  (pair),
    .count_o (cnt),
    .left_o  (lefts),
    .right_o (rights)
  );

  always_ff @(posedge clk_i) begin
    if (step && end_q) begin
      upd_q   <= complete;
      cnt_q   <= complete ? cnt : '0;
      left_q  <= complete ? lefts : '0;
      right_q <= complete ? rights : '0;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign sack_updated_o  = upd_q;
  assign block_count_o   = cnt_q;
  assign block_left_0_o  = left_q[0];
  assign block_right_0_o = right_q[0];
  assign block_left_1_o  = left_q[1];
  assign block_right_1_o = right_q[1];
  assign block_left_2_o  = left_q[2];
  assign block_right_2_o = right_q[2];
  assign block_left_3_o  = left_q[3];
  assign block_right_3_o = right_q[3];

`ifndef SYNTHESIS
  a_count_zero_when_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !upd_q) |-> (cnt_q == '0))
    else $error("block count nonzero without an update");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (cnt_q <= MaxBlocks))
    else $error("block count above store size");

  a_final_byte_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && end_q && out_vld_q && !out_ready_i) |-> !in_ready_o)
    else $error("final byte taken while result register full");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && end_q) |=> out_vld_q)
    else $error("final byte did not produce a result");
`endif

endmodule

`default_nettype wire

@@ rtl/tsop_walk.sv @@
// Option list walker: steps over options, checks the SACK length and
// assembles big-endian edge pairs. Depends on tsop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsop_walk import tsop_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             permitted_i,
  input  wire logic [7:0]       opt_byte_i,
  input  wire logic             end_of_area_i,
  input  wire logic [EdgeW-1:0] send_next_i,
  input  wire logic [EdgeW-1:0] outstanding_bytes_i,
  output pair_t                 pair_o,
  output logic                  complete_o
);

  localparam logic [2:0] PhKind     = 3'd0;
  localparam logic [2:0] PhOptLen   = 3'd1;
  localparam logic [2:0] PhSkip     = 3'd2;
  localparam logic [2:0] PhSackLen  = 3'd3;
  localparam logic [2:0] PhBody     = 3'd4;
  localparam logic [2:0] PhComplete = 3'd5;
  localparam logic [2:0] PhIgnore   = 3'd6;

  logic [2:0]       phase_q, phase_d, phase_cur;
  logic [7:0]       skip_q, skip_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       pos_q, pos_d;
  logic [EdgeW-1:0] shift_q, shift_d;
  logic [EdgeW-1:0] pend_q, pend_d;
  logic [EdgeW-1:0] wnxt_q, wnxt_d;
  logic [EdgeW-1:0] wuna_q, wuna_d;
  logic [CntW-1:0]  read_q, read_d;
  logic [7:0]       len_m2;
  logic [7:0]       b_m2;
  logic             more_pairs;

  assign len_m2 = len_q - 8'd2;
  assign b_m2   = opt_byte_i - 8'd2;
  // Pairs past the option's own count or past the store size are read but ignored.
  assign more_pairs = ({2'b00, read_q} < len_m2[7:3]) && (read_q < MaxBlocks);

  always_comb begin
    phase_cur = permitted_i ? phase_q : PhIgnore;
    phase_d   = phase_cur;
    skip_d    = skip_q;
    len_d     = len_q;
    pos_d     = pos_q;
    shift_d   = shift_q;
    pend_d    = pend_q;
    wnxt_d    = wnxt_q;
    wuna_d    = wuna_q;
    read_d    = read_q;
    pair_o    = '0;
    pair_o.left    = pend_q;
    pair_o.win_una = wuna_q;
    pair_o.win_nxt = wnxt_q;

    case (phase_cur)
      PhKind: begin
        if (end_of_area_i) begin
          phase_d = PhIgnore;
        end else if (opt_byte_i == KindSack) begin
          phase_d = PhSackLen;
        end else if (opt_byte_i == KindEol) begin
          phase_d = PhIgnore;
        end else if (opt_byte_i != KindNop) begin
          phase_d = PhOptLen;
        end
      end
      PhOptLen: begin
        if (opt_byte_i == 8'd0) begin
          phase_d = PhIgnore;
        end else if (opt_byte_i <= 8'd2) begin
          phase_d = PhKind;
        end else begin
          skip_d  = b_m2;
          phase_d = PhSkip;
        end
      end
      PhSkip: begin
        skip_d = skip_q - 8'd1;
        if (skip_d == 8'd0) begin
          phase_d = PhKind;
        end
      end
      PhSackLen: begin
        if ((opt_byte_i < SackMinLen) || (b_m2[2:0] != 3'd0)) begin
          phase_d = PhIgnore;
        end else begin
          len_d        = opt_byte_i;
          pos_d        = 8'd0;
          shift_d      = '0;
          read_d       = '0;
          wnxt_d       = send_next_i;
          wuna_d       = send_next_i - outstanding_bytes_i;
          pair_o.clear = 1'b1;
          phase_d      = PhBody;
        end
      end
      PhBody: begin
        pos_d   = pos_q + 8'd1;
        shift_d = {shift_q[EdgeW-9:0], opt_byte_i};
        if (pos_d[2:0] == PairLeftPos) begin
          pend_d = shift_d;
        end else if ((pos_d[2:0] == PairEndPos) && more_pairs) begin
          pair_o.valid = 1'b1;
          pair_o.right = shift_d;
          read_d       = read_q + 3'd1;
        end
        if (pos_d == len_m2) begin
          phase_d = PhComplete;
        end
      end
      default: begin
      end
    endcase
  end

  assign complete_o = (phase_d == PhComplete);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhKind;
    end else if (step_i) begin
      phase_q <= end_of_area_i ? PhKind : phase_d;
    end
  end

  // Walk payload is always loaded before it is used, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      skip_q  <= skip_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      pend_q  <= pend_d;
      wnxt_q  <= wnxt_d;
      wuna_q  <= wuna_d;
      read_q  <= read_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tsop_blocks.sv @@
// Block store: filters each edge pair against the window and the blocks
// already taken, in serial arithmetic, and keeps the list. Depends on tsop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsop_blocks import tsop_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire pair_t pair_i,
  output logic [CntW-1:0] count_o,
  output edges_t     left_o,
  output edges_t     right_o
);

  edges_t          left_q, right_q, left_d, right_d;
  logic [CntW-1:0] count_q, count_d, count_base;
  logic [EdgeW-1:0] d_span, d_una, d_nxt;
  logic [3:0]      overlap;
  logic            accept;

  function automatic logic ser_pos(input logic [EdgeW-1:0] d);
    ser_pos = (d != '0) && !d[EdgeW-1];
  endfunction

  assign d_span = pair_i.right - pair_i.left;
  assign d_una  = pair_i.left - pair_i.win_una;
  assign d_nxt  = pair_i.win_nxt - pair_i.right;

  // All four overlap checks run side by side; only taken entries count.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      overlap[j] = (3'(j) < count_q) &&
                   ser_pos(pair_i.right - left_q[j]) &&
                   ser_pos(right_q[j] - pair_i.left);
    end
  end

  assign count_base = pair_i.clear ? '0 : count_q;
  assign accept = pair_i.valid && ser_pos(d_span) && ser_pos(d_una) &&
                  !d_nxt[EdgeW-1] && (overlap == 4'b0000) && (count_base < MaxBlocks);

  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    count_d = count_base;
    if (accept) begin
      left_d[count_base[1:0]]  = pair_i.left;
      right_d[count_base[1:0]] = pair_i.right;
      count_d                  = count_base + 3'd1;
    end
  end

  // The list as it stands after this byte; entries past the count read as zero.
  always_comb begin
    count_o = count_d;
    for (int k = 0; k < 4; k++) begin
      left_o[k]  = (3'(k) < count_d) ? left_d[k]  : '0;
      right_o[k] = (3'(k) < count_d) ? right_d[k] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (step_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for tcp_sack_option_parser_core: option areas go in one byte per transfer,
// and each SACK result is checked against an in-bench model of the option walk and
// block filter. Depends on tsop_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
  import tsop_pkg::*;

  localparam int AreaMaxBytes = 48;
  localparam int SettleCycles = 4;
  localparam int IdleLimit    = 5000;
  localparam int ByteTarget   = 1200;
  localparam int ReportMax    = 10;
  localparam int NumRows      = 17;

  typedef logic [8*AreaMaxBytes-1:0] area_vec_t;

  typedef enum logic [2:0] {
    WalkKind, WalkOptLen, WalkSkip, WalkSackLen, WalkBody, WalkDone, WalkIgnore
  } walk_e;

  typedef struct packed {
    logic            updated;
    logic [CntW-1:0] count;
    edges_t          left;
    edges_t          right;
  } sack_result_t;

  typedef struct {
    int               nbytes;
    area_vec_t        area;        // first byte sits in the highest used position
    logic [EdgeW-1:0] snd_nxt;
    logic [EdgeW-1:0] in_flight;
    bit               permit;
    int               drop_at;     // permission is withdrawn before this byte, -1 if never
    bit               typed_none;  // result known at a glance: no update
  } area_row_t;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic             cfg_wdata = 1'b0;
  logic             in_valid  = 1'b0;
  logic [7:0]       opt_byte  = '0;
  logic             end_flag  = 1'b0;
  logic [EdgeW-1:0] snd_nxt   = '0;
  logic [EdgeW-1:0] in_flight = '0;
  logic             out_ready = 1'b0;

  logic             in_ready;
  logic             out_valid;
  logic             sack_updated;
  logic [CntW-1:0]  block_count;
  logic [EdgeW-1:0] bl0, br0, bl1, br1, bl2, br2, bl3, br3;
  edges_t           got_left, got_right;

  assign got_left  = {bl3, bl2, bl1, bl0};
  assign got_right = {br3, br2, br1, br0};

  tcp_sack_option_parser_core i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .opt_byte_i          (opt_byte),
    .end_of_area_i       (end_flag),
    .send_next_i         (snd_nxt),
    .outstanding_bytes_i (in_flight),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .sack_updated_o      (sack_updated),
    .block_count_o       (block_count),
    .block_left_0_o      (bl0),
    .block_right_0_o     (br0),
    .block_left_1_o      (bl1),
    .block_right_1_o     (br1),
    .block_left_2_o      (bl2),
    .block_right_2_o     (br2),
    .block_left_3_o      (bl3),
    .block_right_3_o     (br3)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Option walk and block filter as the bench sees them.
  bit               permit_now     = 1'b0;
  walk_e            opt_phase      = WalkKind;
  logic [7:0]       skip_left      = '0;
  logic [7:0]       sack_len_seen  = '0;
  logic [7:0]       sack_pos       = '0;
  logic [EdgeW-1:0] edge_acc       = '0;
  logic [EdgeW-1:0] left_edge_hold = '0;
  logic [EdgeW-1:0] win_hi         = '0;
  logic [EdgeW-1:0] win_lo         = '0;
  logic [EdgeW-1:0] kept_left [4]  = '{default: '0};
  logic [EdgeW-1:0] kept_right [4] = '{default: '0};
  int               kept_n         = 0;
  int               pairs_walked   = 0;

  sack_result_t     sack_due [$];
  sack_result_t     due_now;
  int               sack_errors    = 0;
  int               burst_left     = 0;
  int               fed_bytes      = 0;
  int               quiet_cycles   = 0;
  int               rx_mode        = 0;
  int               rx_run         = 0;
  logic [7:0]       area_q [$];

  function automatic bit serial_gt0(logic [EdgeW-1:0] d);
    return d != '0 && !d[EdgeW-1];
  endfunction

  function automatic void offer_pair(logic [EdgeW-1:0] l, logic [EdgeW-1:0] r);
    logic [EdgeW-1:0] room;
    room = win_hi - r;
    if (!serial_gt0(r - l)) return;
    if (!serial_gt0(l - win_lo) || room[EdgeW-1]) return;
    for (int j = 0; j < kept_n; j++) begin
      if (serial_gt0(r - kept_left[j]) && serial_gt0(kept_right[j] - l)) return;
    end
    if (kept_n < int'(MaxBlocks)) begin
      kept_left[kept_n]  = l;
      kept_right[kept_n] = r;
      kept_n++;
    end
  endfunction

  // Advances the walk by one byte; returns 1 when the byte closes an area.
  function automatic bit walk_option_byte(input logic [7:0] b, input bit last,
                                          input logic [EdgeW-1:0] nxt,
                                          input logic [EdgeW-1:0] flight,
                                          output sack_result_t res);
    int limit;
    res = '0;
    if (!permit_now) opt_phase = WalkIgnore;
    case (opt_phase)
      WalkKind: begin
        if (last) opt_phase = WalkIgnore;
        else if (b == KindSack) opt_phase = WalkSackLen;
        else if (b == KindEol) opt_phase = WalkIgnore;
        else if (b != KindNop) opt_phase = WalkOptLen;
      end
      WalkOptLen: begin
        if (b == 8'd0) begin
          opt_phase = WalkIgnore;
        end else if (b <= 8'd2) begin
          opt_phase = WalkKind;
        end else begin
          skip_left = b - 8'd2;
          opt_phase = WalkSkip;
        end
      end
      WalkSkip: begin
        skip_left = skip_left - 8'd1;
        if (skip_left == 8'd0) opt_phase = WalkKind;
      end
      WalkSackLen: begin
        // The length must be 2 plus a whole number of 8-byte pairs.
        if (b < SackMinLen || b[2:0] != 3'd2) begin
          opt_phase = WalkIgnore;
        end else begin
          sack_len_seen = b;
          sack_pos      = '0;
          edge_acc      = '0;
          kept_n        = 0;
          pairs_walked  = 0;
          win_hi        = nxt;
          win_lo        = nxt - flight;
          opt_phase     = WalkBody;
        end
      end
      WalkBody: begin
        sack_pos = sack_pos + 8'd1;
        edge_acc = {edge_acc[EdgeW-9:0], b};
        limit = (int'(sack_len_seen) - 2) / 8;
        if (limit > int'(MaxBlocks)) limit = int'(MaxBlocks);
        if (sack_pos[2:0] == 3'd4) begin
          left_edge_hold = edge_acc;
        end else if (sack_pos[2:0] == 3'd0) begin
          if (pairs_walked < limit) begin
            offer_pair(left_edge_hold, edge_acc);
            pairs_walked++;
          end
        end
        if (sack_pos == sack_len_seen - 8'd2) opt_phase = WalkDone;
      end
      default: ;
    endcase
    if (!last) return 1'b0;
    if (opt_phase == WalkDone) begin
      res.updated = 1'b1;
      res.count   = CntW'(kept_n);
      for (int k = 0; k < kept_n; k++) begin
        res.left[k]  = kept_left[k];
        res.right[k] = kept_right[k];
      end
    end
    opt_phase      = WalkKind;
    skip_left      = '0;
    sack_len_seen  = '0;
    sack_pos       = '0;
    edge_acc       = '0;
    left_edge_hold = '0;
    win_hi         = '0;
    win_lo         = '0;
    kept_n         = 0;
    pairs_walked   = 0;
    return 1'b1;
  endfunction

  function automatic void flag_error(string what);
    sack_errors++;
    if (sack_errors <= ReportMax) $display("%0t: %s", $time, what);
  endfunction

  function automatic void check_field(string name, logic [EdgeW-1:0] got,
                                      logic [EdgeW-1:0] want);
    if (got !== want) begin
      flag_error($sformatf("mismatch on %s: expected %h, got %h", name, want, got));
    end
  endfunction

  // Sender: bursts of random length, gaps between them.
  task automatic push_byte(input logic [7:0] b, input bit last,
                           input logic [EdgeW-1:0] nxt, input logic [EdgeW-1:0] flight,
                           input bit typed_none);
    sack_result_t res;
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    opt_byte  <= b;
    end_flag  <= last;
    snd_nxt   <= nxt;
    in_flight <= flight;
    do @(posedge clk); while (!in_ready);
    fed_bytes++;
    if (walk_option_byte(b, last, nxt, flight, res)) begin
      if (typed_none) sack_due.push_back('0);
      else sack_due.push_back(res);
    end
  endtask

  // Waits until the parser is idle, then writes sack_permitted.
  task automatic set_permit(input bit v);
    in_valid <= 1'b0;
    while (sack_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    permit_now = v;
  endtask

  function automatic void push_word(logic [EdgeW-1:0] w);
    area_q.push_back(w[31:24]);
    area_q.push_back(w[23:16]);
    area_q.push_back(w[15:8]);
    area_q.push_back(w[7:0]);
  endfunction

  // Builds one option area: mostly other options followed by a SACK option, some of
  // them truncated or with a bad length, and some plain noise.
  function automatic void build_area(input logic [EdgeW-1:0] nxt,
                                     input logic [EdgeW-1:0] flight);
    logic [EdgeW-1:0] una, l, r, prev_l, prev_r;
    logic [7:0]       len_b;
    int shape, npairs, kind, olen, cut;
    una    = nxt - flight;
    prev_l = una + 1;
    prev_r = una + 100;
    area_q.delete();
    shape = $urandom_range(0, 99);
    if (shape >= 88) begin
      repeat ($urandom_range(1, 40)) area_q.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0: area_q.push_back(KindNop);
        1: begin
          area_q.push_back(8'd2);
          area_q.push_back(8'd4);
          repeat (2) area_q.push_back(8'($urandom));
        end
        2: begin
          area_q.push_back(8'd3);
          area_q.push_back(8'd3);
          area_q.push_back(8'($urandom));
        end
        3: begin
          area_q.push_back(8'd8);
          area_q.push_back(8'd10);
          repeat (8) area_q.push_back(8'($urandom));
        end
        default: begin
          kind = $urandom_range(2, 255);
          if (kind == int'(KindSack)) kind = kind + 1;
          olen = $urandom_range(2, 8);
          area_q.push_back(8'(kind));
          area_q.push_back(8'(olen));
          repeat (olen - 2) area_q.push_back(8'($urandom));
        end
      endcase
    end
    npairs = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 31) : $urandom_range(1, 4);
    area_q.push_back(KindSack);
    if (shape >= 78) begin
      len_b = 8'($urandom);
      if (len_b >= SackMinLen && len_b[2:0] == 3'd2) len_b = len_b + 8'd1;
      area_q.push_back(len_b);
    end else begin
      area_q.push_back(8'(2 + 8 * npairs));
    end
    repeat (npairs) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          l = una + $urandom_range(0, flight);
          r = l + $urandom_range(0, 3000);
        end
        5: begin
          // Near the previous pair, so the overlap check gets exercised.
          l = prev_l + $urandom_range(0, 40) - 20;
          r = prev_r + $urandom_range(0, 40) - 20;
        end
        6: begin
          l = una + $urandom_range(0, flight);
          r = l - $urandom_range(0, 50);
        end
        7: begin
          l = $urandom;
          r = $urandom;
        end
        8: begin
          l = una;
          r = una + $urandom_range(1, 100);
        end
        default: begin
          r = nxt + $urandom_range(0, 1);
          l = r - $urandom_range(1, 100);
        end
      endcase
      push_word(l);
      push_word(r);
      prev_l = l;
      prev_r = r;
    end
    repeat ($urandom_range(0, 2)) area_q.push_back(8'($urandom));
    if (shape >= 70 && shape < 78) begin
      cut = $urandom_range(1, area_q.size() - 1);
      while (area_q.size() > cut) void'(area_q.pop_back());
    end
  endfunction

  // Default window: snd_nxt 1000, snd_una 500.
  area_row_t area_table [NumRows] = '{
    '{10, area_vec_t'({KindSack, 8'd10, 32'd600, 32'd700}),
      32'd1000, 32'd500, 1'b0, -1, 1'b1},
    '{1, area_vec_t'({KindNop}), 32'd1000, 32'd500, 1'b1, -1, 1'b1},
    '{2, area_vec_t'({KindNop, KindSack}), 32'd1000, 32'd500, 1'b1, -1, 1'b1},
    '{12, area_vec_t'({KindNop, KindNop, KindSack, 8'd10, 32'd600, 32'd700}),
      32'd1000, 32'd500, 1'b1, -1, 1'b0},
    '{11, area_vec_t'({KindEol, KindSack, 8'd10, 32'd600, 32'd700}),
      32'd1000, 32'd500, 1'b1, -1, 1'b1},
    '{12, area_vec_t'({8'h02, 8'h00, KindSack, 8'd10, 32'd600, 32'd700}),
      32'd1000, 32'd500, 1'b1, -1, 1'b1},
    '{12, area_vec_t'({8'h03, 8'h01, KindSack, 8'd10, 32'd600, 32'd700}),
      32'd1000, 32'd500, 1'b1, -1, 1'b0},
    '{17, area_vec_t'({8'hFF, 8'h03, 8'hAA, 8'h02, 8'h04, 8'h05, 8'hB4,
                       KindSack, 8'd10, 32'd600, 32'd700}),
      32'd1000, 32'd500, 1'b1, -1, 1'b0},
    '{5, area_vec_t'({8'h08, 8'd10, 8'h01, 8'h02, 8'h03}),
      32'd1000, 32'd500, 1'b1, -1, 1'b1},
    '{10, area_vec_t'({KindSack, 8'd18, 32'd600, 32'd700}),
      32'd1000, 32'd500, 1'b1, -1, 1'b1},
    '{10, area_vec_t'({KindSack, 8'd9, 32'd600, 32'd700}),
      32'd1000, 32'd500, 1'b1, -1, 1'b1},
    '{10, area_vec_t'({KindSack, 8'd11, 32'd600, 32'd700}),
      32'd1000, 32'd500, 1'b1, -1, 1'b1},
    // Five pairs: two taken, an empty one, an overlapping one, the fifth never looked at.
    '{42, area_vec_t'({KindSack, 8'd42,
                       32'h8000_0000, 32'h8000_0100, 32'hFFFF_FF00, 32'hFFFF_FFF0,
                       32'h9000_0000, 32'h9000_0000, 32'h8000_0050, 32'h8000_0200,
                       32'hC000_0000, 32'hC000_0001}),
      32'hFFFF_FFF0, 32'h8000_0000, 1'b1, -1, 1'b0},
    '{13, area_vec_t'({KindSack, 8'd10, 32'd600, 32'd700, 8'h01, 8'h02, 8'hFF}),
      32'd1000, 32'd500, 1'b1, -1, 1'b0},
    // The window wraps through zero.
    '{34, area_vec_t'({KindSack, 8'd34,
                       32'hFFFF_FFF8, 32'h0000_0008, 32'hFFFF_FFF0, 32'hFFFF_FFF4,
                       32'h0000_0008, 32'h0000_0011, 32'h0000_0009, 32'h0000_0005}),
      32'h0000_0010, 32'h0000_0020, 1'b1, -1, 1'b0},
    '{11, area_vec_t'({KindNop, KindSack, 8'd10, 32'd600, 32'd700}),
      32'd1000, 32'd500, 1'b1, 2, 1'b1},
    '{18, area_vec_t'({KindSack, 8'd18,
                       32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF}),
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, -1, 1'b0}
  };

  // Receiver: stretches of always-ready and of stalls of varying density.
  always @(posedge clk) begin
    if (rx_run == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_run  = $urandom_range(20, 200);
    end
    rx_run = rx_run - 1;
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 19) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sack_due.size() == 0) begin
        flag_error("SACK result arrived with no area pending");
      end else begin
        due_now = sack_due.pop_front();
        check_field("sack_updated", EdgeW'(sack_updated), EdgeW'(due_now.updated));
        check_field("block_count", EdgeW'(block_count), EdgeW'(due_now.count));
        for (int k = 0; k < 4; k++) begin
          check_field($sformatf("block_left_%0d", k), got_left[k], due_now.left[k]);
          check_field($sformatf("block_right_%0d", k), got_right[k], due_now.right[k]);
        end
      end
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [EdgeW-1:0] nxt, flight;
    int cfg_countdown;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumRows; i++) begin
      if (i == 0 || area_table[i].permit != permit_now) set_permit(area_table[i].permit);
      for (int k = 0; k < area_table[i].nbytes; k++) begin
        if (k == area_table[i].drop_at) set_permit(1'b0);
        push_byte(area_table[i].area[8*(area_table[i].nbytes-1-k) +: 8],
                  k == area_table[i].nbytes - 1, area_table[i].snd_nxt,
                  area_table[i].in_flight, area_table[i].typed_none);
      end
    end

    cfg_countdown = 0;
    while (fed_bytes < ByteTarget) begin
      if (cfg_countdown == 0) begin
        set_permit($urandom_range(0, 5) != 0);
        cfg_countdown = $urandom_range(10, 30);
      end
      cfg_countdown--;
      nxt = $urandom;
      case ($urandom_range(0, 9))
        7:       flight = $urandom;
        8:       flight = '0;
        9:       flight = $urandom_range(0, 16);
        default: flight = $urandom_range(1, 65535);
      endcase
      build_area(nxt, flight);
      foreach (area_q[k]) push_byte(area_q[k], k == area_q.size() - 1, nxt, flight, 1'b0);
    end

    in_valid <= 1'b0;
    while (sack_due.size() != 0) @(posedge clk);
    repeat (2 * SettleCycles) @(posedge clk);
    if (sack_errors == 0 && sack_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
